@@ hw/rtl/wam_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wam_pkg
// Shared constants for the windowed average, minimum and maximum core.
// ----------------------------------------------------------------------------
package wam_pkg;

	localparam int DEPTH_DEF       = 256;
	localparam int SAMPLE_BITS_DEF = 32;

	// Fixed widths of the result fields.
	localparam int OUT_BITS       = 32;
	localparam int COUNT_OUT_BITS = 9;

	// Request operation codes.
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

endpackage : wam_pkg
`default_nettype wire

@@ hw/rtl/windowed_average_min_max_core.sv @@
`default_nettype none
// Datapath: each request passes the apply, subtract, magnitude and divide states, the
//   last a one-bit-per-cycle restoring divider over the TOTAL_W-bit window total.
// Flow: one request at a time; a new request is taken once the previous result
//   is loaded into the output register, also while that result still waits there.
// Reset: arst_n clears control, count, total, extremes and write position at once.
//   The sample ring is not cleared; only entries written since the last clear are used.
// ----------------------------------------------------------------------------
// windowed_average_min_max_core
// Keeps a ring of the last DEPTH samples in a synchronous memory with their exact
// running total, and returns the window average with the running extremes.
// ----------------------------------------------------------------------------
module windowed_average_min_max_core #(
	parameter int DEPTH       = wam_pkg::DEPTH_DEF,
	parameter int SAMPLE_BITS = wam_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   req_valid,
	output logic                                        req_ready,
	input  wire logic                                   operation,
	input  wire logic signed [SAMPLE_BITS-1:0]          sample,
	output logic                                        rsp_valid,
	input  wire logic                                   rsp_ready,
	output logic signed [wam_pkg::OUT_BITS-1:0]         average,
	output logic signed [wam_pkg::OUT_BITS-1:0]         minimum,
	output logic signed [wam_pkg::OUT_BITS-1:0]         maximum,
	output logic        [wam_pkg::COUNT_OUT_BITS-1:0]   sample_count,
	output logic                                        extremes_valid
);
	import wam_pkg::*;

	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COUNT_W = $clog2(DEPTH + 1);
	// One guard bit so the magnitude of any total fits unsigned.
	localparam int TOTAL_W = SAMPLE_BITS + AW + 1;
	localparam int STEP_W  = $clog2(TOTAL_W + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_APPLY = 3'd1;
	localparam logic [2:0] S_SUB   = 3'd2;
	localparam logic [2:0] S_ABS   = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0] state_q;

	logic                          op_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [AW-1:0]                 wpos_q;
	logic [COUNT_W-1:0]            count_q;
	logic signed [TOTAL_W-1:0]     total_q;
	logic signed [SAMPLE_BITS-1:0] least_q;
	logic signed [SAMPLE_BITS-1:0] greatest_q;
	logic                          started_q;
	logic                          was_full_q;

	logic                          neg_q;
	logic [TOTAL_W-1:0]            dvd_q;
	logic [COUNT_W-1:0]            rem_q;
	logic [STEP_W-1:0]             step_q;

	logic signed [SAMPLE_BITS-1:0] ring [DEPTH];
	logic signed [SAMPLE_BITS-1:0] rd_q;

	logic rsp_valid_q;
	logic signed [OUT_BITS-1:0]       average_q;
	logic signed [OUT_BITS-1:0]       minimum_q;
	logic signed [OUT_BITS-1:0]       maximum_q;
	logic        [COUNT_OUT_BITS-1:0] count_out_q;
	logic                             ext_valid_q;

	logic accept;
	logic ring_we;
	logic full;
	logic load_out;

	logic [COUNT_W:0]     rem_shift;
	logic [COUNT_W:0]     rem_diff;
	logic                 rem_ge;
	logic [TOTAL_W-1:0]   quot;
	logic [TOTAL_W+OUT_BITS-1:0]     quot_ext;
	logic [SAMPLE_BITS+OUT_BITS-1:0] least_ext;
	logic [SAMPLE_BITS+OUT_BITS-1:0] greatest_ext;
	logic [COUNT_W+COUNT_OUT_BITS-1:0] count_ext;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);
	assign ring_we   = (state_q == S_APPLY) && (op_q == OP_ADD);
	assign full      = (count_q == COUNT_W'(DEPTH));
	assign load_out  = (state_q == S_FIN) && (!rsp_valid_q || rsp_ready);

	// The entry under the write position is read at accept time; it is the
	// oldest sample once the window is full, and an add overwrites it in the apply state.
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring[wpos_q] <= sample_q;
		end
		if (accept) begin
			rd_q <= ring[wpos_q];
		end
	end

	// One restoring division step per cycle on the total's magnitude.
	assign rem_shift = {rem_q, dvd_q[TOTAL_W-1]};
	assign rem_diff  = rem_shift - {1'b0, count_q};
	assign rem_ge    = !rem_diff[COUNT_W];
	assign quot      = neg_q ? (~dvd_q + TOTAL_W'(1)) : dvd_q;

	assign quot_ext     = {{OUT_BITS{quot[TOTAL_W-1]}}, quot};
	assign least_ext    = {{OUT_BITS{least_q[SAMPLE_BITS-1]}}, least_q};
	assign greatest_ext = {{OUT_BITS{greatest_q[SAMPLE_BITS-1]}}, greatest_q};
	assign count_ext    = {{COUNT_OUT_BITS{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			wpos_q     <= '0;
			count_q    <= '0;
			total_q    <= '0;
			least_q    <= '0;
			greatest_q <= '0;
			started_q  <= 1'b0;
			was_full_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (op_q == OP_CLEAR) begin
						count_q    <= '0;
						total_q    <= '0;
						started_q  <= 1'b0;
						was_full_q <= 1'b0;
					end else begin
						total_q    <= total_q + TOTAL_W'(sample_q);
						was_full_q <= full;
						if (!full) begin
							count_q <= count_q + COUNT_W'(1);
						end
						if (wpos_q == AW'(DEPTH - 1)) begin
							wpos_q <= '0;
						end else begin
							wpos_q <= wpos_q + AW'(1);
						end
						started_q <= 1'b1;
						if (!started_q || sample_q < least_q) begin
							least_q <= sample_q;
						end
						if (!started_q || sample_q > greatest_q) begin
							greatest_q <= sample_q;
						end
					end
					state_q <= S_SUB;
				end
				S_SUB: begin
					if (was_full_q) begin
						total_q <= total_q - TOTAL_W'(rd_q);
					end
					state_q <= S_ABS;
				end
				S_ABS: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (step_q == STEP_W'(TOTAL_W - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request and divider datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= operation;
			sample_q <= sample;
		end
		if (state_q == S_ABS) begin
			neg_q  <= total_q[TOTAL_W-1];
			dvd_q  <= total_q[TOTAL_W-1] ? (~total_q + TOTAL_W'(1)) : total_q;
			rem_q  <= '0;
			step_q <= '0;
		end else if (state_q == S_DIV) begin
			rem_q  <= rem_ge ? rem_diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
			dvd_q  <= {dvd_q[TOTAL_W-2:0], rem_ge};
			step_q <= step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			average_q   <= (count_q == '0) ? '0 : quot_ext[OUT_BITS-1:0];
			minimum_q   <= started_q ? least_ext[OUT_BITS-1:0] : '0;
			maximum_q   <= started_q ? greatest_ext[OUT_BITS-1:0] : '0;
			count_out_q <= count_ext[COUNT_OUT_BITS-1:0];
			ext_valid_q <= started_q;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign average        = average_q;
	assign minimum        = minimum_q;
	assign maximum        = maximum_q;
	assign sample_count   = count_out_q;
	assign extremes_valid = ext_valid_q;

endmodule : windowed_average_min_max_core
`default_nettype wire
